@@ sv/sppd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sppd_pkg;

	// Field widths
	localparam int SAL_W     = 16;
	localparam int BINS_W    = 10;
	localparam int THR_W     = 16;
	localparam int PITCH_W   = 15;
	localparam int PEAKBIN_W = 9;
	localparam int SPAN_W    = 15;
	localparam int QUO_W     = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BINS = 2'd0,
		REG_THR  = 2'd1,
		REG_LO   = 2'd2,
		REG_HI   = 2'd3
	} cfg_reg_t;

	localparam logic [BINS_W-1:0]  BINS_RST = 10'd360;
	localparam logic [THR_W-1:0]   THR_RST  = 16'd3277;
	localparam logic [PITCH_W-1:0] LO_RST   = 15'd6144;
	localparam logic [PITCH_W-1:0] HI_RST   = 15'd24320;
	localparam logic [PITCH_W-1:0] PITCH_MAX = 15'h7FFF;

	// One operation issued to the shared multiply-accumulate unit
	typedef struct packed {
		logic vld;   // operation present
		logic clr;   // start a new sum
		logic hi;    // product is the upper partial product
	} mac_ctl_t;

endpackage

`default_nettype wire

@@ sv/sppd_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sppd_in_if
	import sppd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [SAL_W-1:0]  salience;
	logic              end_of_row;

	modport source (output valid, salience, end_of_row, input ready);
	modport sink   (input valid, salience, end_of_row, output ready);
endinterface

`default_nettype wire

@@ sv/sppd_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sppd_out_if
	import sppd_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic                  voiced;
	logic [SAL_W-1:0]      confidence;
	logic [PEAKBIN_W-1:0]  peak_bin;
	logic [PITCH_W-1:0]    pitch;

	modport source (output valid, voiced, confidence, peak_bin, pitch, input ready);
	modport sink   (input valid, voiced, confidence, peak_bin, pitch, output ready);
endinterface

`default_nettype wire

@@ sv/salience_peak_pitch_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bins stream in at one per cycle; the row goes to a RAM while the first peak is tracked.
// On the end-of-row beat the block drops ready: unvoiced rows go straight to the result
// register, while voiced rows first run the window walk on the RAM read port, then the
// shared multiply-accumulate and a restoring divider.
// Reset (arst_n low) clears the row state, loads the register defaults; RAM is not cleared.
module salience_peak_pitch_decoder
	import sppd_pkg::*;
#(
	parameter int MAX_BINS    = 512,
	parameter int HALF_WINDOW = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	sppd_in_if.sink                    bin_ch,
	sppd_out_if.source                 res_ch
);

	localparam int IW     = $clog2(MAX_BINS);
	localparam int CW     = $clog2(MAX_BINS + 1);
	localparam int LW     = (CW > BINS_W) ? CW : BINS_W;
	localparam int WW     = SAL_W + $clog2(2 * HALF_WINDOW + 1);
	localparam int SW     = WW + IW;
	localparam int HALF   = (SW + 1) / 2;
	localparam int BW     = SPAN_W;
	localparam int ACCW   = SPAN_W + SW;
	localparam int DEN_W  = WW + BINS_W;
	localparam int VW     = DEN_W + 1;
	localparam int NW     = (ACCW + 2 > VW + QUO_W) ? ACCW + 2 : VW + QUO_W;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_WALK = 10'b0000000010,
		ST_SUMS = 10'b0000000100,
		ST_DEN  = 10'b0000001000,
		ST_DENW = 10'b0000010000,
		ST_MAGL = 10'b0000100000,
		ST_MAGH = 10'b0001000000,
		ST_MAGW = 10'b0010000000,
		ST_DIV  = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [BINS_W-1:0]  bins_q;
	logic [THR_W-1:0]   thr_q;
	logic [PITCH_W-1:0] lo_q;
	logic [PITCH_W-1:0] hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q <= BINS_RST;
			thr_q  <= THR_RST;
			lo_q   <= LO_RST;
			hi_q   <= HI_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_BINS: bins_q <= cfg_data[BINS_W-1:0];
				REG_THR:  thr_q  <= cfg_data[THR_W-1:0];
				REG_LO:   lo_q   <= cfg_data[PITCH_W-1:0];
				REG_HI:   hi_q   <= cfg_data[PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	// row state
	logic [CW-1:0]    cnt_q;
	logic [SAL_W-1:0] peak_q;
	logic [IW-1:0]    pkidx_q;

	// tail state
	logic [SAL_W-1:0] conf_q;
	logic [IW-1:0]    pkb_q;
	logic [IW-1:0]    walk_q;
	logic [IW-1:0]    last_q;
	logic             walk_first_q;
	logic             rd_vld_s1;
	logic             rd_first_s1;
	logic [IW-1:0]    rd_idx_s1;
	logic [WW-1:0]    wsum_q;
	logic [SW-1:0]    ssum_q;
	logic [DEN_W-1:0] den_q;
	logic             res_voiced_q;
	logic [PITCH_W-1:0] res_pitch_q;

	// result register
	logic               out_vld_q;
	logic               out_voiced_q;
	logic [SAL_W-1:0]   out_conf_q;
	logic [PEAKBIN_W-1:0] out_pkb_q;
	logic [PITCH_W-1:0] out_pitch_q;

	// streaming side
	logic              in_acc;
	logic [LW-1:0]     bins_ext;
	logic [LW-1:0]     limit;
	logic [LW-1:0]     limit_m1;
	logic [BINS_W-1:0] dm1;
	logic              take;
	logic              upd;
	logic [SAL_W-1:0]  peak_nx;
	logic [IW-1:0]     pkidx_nx;
	logic [CW-1:0]     cnt_nx;
	logic [IW:0]       pk_w;
	logic [IW:0]       hw_w;
	logic [IW:0]       last_w;
	logic [IW-1:0]     nm1;
	logic [IW-1:0]     first_nx;
	logic [IW-1:0]     last_nx;
	logic              voiced_nx;

	assign in_acc   = bin_ch.valid && bin_ch.ready;
	assign bins_ext = LW'(bins_q);
	assign limit    = (bins_ext == '0) ? LW'(1) :
	                  ((bins_ext > LW'(MAX_BINS)) ? LW'(MAX_BINS) : bins_ext);
	assign limit_m1 = limit - LW'(1);
	assign dm1      = (limit > LW'(1)) ? limit_m1[BINS_W-1:0] : BINS_W'(1);

	assign take     = LW'(cnt_q) < limit;
	assign upd      = take && ((cnt_q == '0) || (bin_ch.salience > peak_q));
	assign peak_nx  = upd ? bin_ch.salience : peak_q;
	assign pkidx_nx = upd ? IW'(cnt_q) : pkidx_q;
	assign cnt_nx   = take ? cnt_q + CW'(1) : cnt_q;

	// window around the peak, clipped to the bins of this row
	assign pk_w     = (IW+1)'(pkidx_nx);
	assign hw_w     = (IW+1)'(HALF_WINDOW);
	assign last_w   = pk_w + hw_w;
	assign nm1      = IW'(cnt_nx - CW'(1));
	assign first_nx = (pk_w > hw_w) ? IW'(pk_w - hw_w) : '0;
	assign last_nx  = (last_w > (IW+1)'(nm1)) ? nm1 : IW'(last_w);
	assign voiced_nx = peak_nx > thr_q;

	// pitch map span
	logic               neg;
	logic [SPAN_W-1:0]  span;

	assign neg  = hi_q < lo_q;
	assign span = neg ? SPAN_W'(lo_q - hi_q) : SPAN_W'(hi_q - lo_q);

	// row store
	logic [SAL_W-1:0] ram_rdata;

	sppd_ram #(
		.WIDTH (SAL_W),
		.DEPTH (MAX_BINS)
	) u_row (
		.clk   (clk),
		.we    (in_acc && take),
		.waddr (IW'(cnt_q)),
		.wdata (bin_ch.salience),
		.raddr (walk_q),
		.rdata (ram_rdata)
	);

	// shared multiply-accumulate
	mac_ctl_t        mac_ctl;
	logic [WW-1:0]   mac_a;
	logic [BW-1:0]   mac_b;
	logic            mac_busy;
	logic [ACCW-1:0] mac_acc;

	always_comb begin
		mac_ctl = '0;
		mac_a   = '0;
		mac_b   = '0;
		if (rd_vld_s1) begin
			mac_ctl.vld = 1'b1;
			mac_ctl.clr = rd_first_s1;
			mac_a       = WW'(ram_rdata);
			mac_b       = BW'(rd_idx_s1);
		end
		case (state_q)
			ST_DEN: begin
				mac_ctl = '{vld: 1'b1, clr: 1'b1, hi: 1'b0};
				mac_a   = wsum_q;
				mac_b   = BW'(dm1);
			end
			ST_MAGL: begin
				mac_ctl = '{vld: 1'b1, clr: 1'b1, hi: 1'b0};
				mac_a   = WW'(ssum_q[HALF-1:0]);
				mac_b   = span;
			end
			ST_MAGH: begin
				mac_ctl = '{vld: 1'b1, clr: 1'b0, hi: 1'b1};
				mac_a   = WW'(ssum_q[SW-1:HALF]);
				mac_b   = span;
			end
			default: ;
		endcase
	end

	sppd_mac #(
		.AW    (WW),
		.BW    (BW),
		.ACCW  (ACCW),
		.SHIFT (HALF)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.busy   (mac_busy),
		.acc    (mac_acc)
	);

	// rounded quotient of span*S / (W*D)
	logic              div_start;
	logic              div_done;
	logic [QUO_W-1:0]  div_quo;
	logic [NW-1:0]     div_num;

	assign div_start = (state_q == ST_MAGW) && !mac_busy;
	assign div_num   = (NW'(mac_acc) << 1) + NW'(den_q);

	sppd_div #(
		.NW (NW),
		.VW (VW),
		.QW (QUO_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.dvs    ({den_q, 1'b0}),
		.done   (div_done),
		.quo    (div_quo)
	);

	// offset up or down from lo_q, saturated to the pitch range
	logic [PITCH_W+1:0] up_sum;
	logic [PITCH_W-1:0] pitch_nx;

	assign up_sum = (PITCH_W+2)'(lo_q) + (PITCH_W+2)'(div_quo);

	always_comb begin
		if (neg) begin
			pitch_nx = (div_quo > QUO_W'(lo_q)) ? '0 : PITCH_W'(QUO_W'(lo_q) - div_quo);
		end else begin
			pitch_nx = (up_sum > (PITCH_W+2)'(PITCH_MAX)) ? PITCH_MAX : up_sum[PITCH_W-1:0];
		end
	end

	logic sums_done;
	logic out_free;

	assign sums_done = !rd_vld_s1 && !mac_busy;
	assign out_free  = !out_vld_q || res_ch.ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			peak_q       <= '0;
			pkidx_q      <= '0;
			rd_vld_s1    <= 1'b0;
			walk_first_q <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_WALK);
			// load a new beat, or drop the held one once it is taken
			if ((state_q == ST_OUT) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (bin_ch.end_of_row) begin
							cnt_q        <= '0;
							peak_q       <= '0;
							pkidx_q      <= '0;
							walk_first_q <= 1'b1;
							state_q      <= voiced_nx ? ST_WALK : ST_OUT;
						end else begin
							cnt_q   <= cnt_nx;
							peak_q  <= peak_nx;
							pkidx_q <= pkidx_nx;
						end
					end
				end
				ST_WALK: begin
					walk_first_q <= 1'b0;
					if (walk_q == last_q) begin
						state_q <= ST_SUMS;
					end
				end
				ST_SUMS: begin
					if (sums_done) begin
						state_q <= (wsum_q == '0) ? ST_OUT : ST_DEN;
					end
				end
				ST_DEN:  state_q <= ST_DENW;
				ST_DENW: begin
					if (!mac_busy) begin
						state_q <= ST_MAGL;
					end
				end
				ST_MAGL: state_q <= ST_MAGH;
				ST_MAGH: state_q <= ST_MAGW;
				ST_MAGW: begin
					if (!mac_busy) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_idx_s1   <= walk_q;
		rd_first_s1 <= walk_first_q;
		if (rd_vld_s1) begin
			wsum_q <= (rd_first_s1 ? '0 : wsum_q) + WW'(ram_rdata);
		end
		case (state_q)
			ST_IDLE: begin
				if (in_acc && bin_ch.end_of_row) begin
					conf_q       <= peak_nx;
					pkb_q        <= pkidx_nx;
					walk_q       <= first_nx;
					last_q       <= last_nx;
					res_voiced_q <= 1'b0;
					res_pitch_q  <= '0;
				end
			end
			ST_WALK: begin
				if (walk_q != last_q) begin
					walk_q <= walk_q + IW'(1);
				end
			end
			ST_SUMS: begin
				if (sums_done) begin
					ssum_q <= SW'(mac_acc);
				end
			end
			ST_DENW: begin
				if (!mac_busy) begin
					den_q <= DEN_W'(mac_acc);
				end
			end
			ST_DIV: begin
				if (div_done) begin
					res_voiced_q <= 1'b1;
					res_pitch_q  <= pitch_nx;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_voiced_q <= res_voiced_q;
					out_conf_q   <= conf_q;
					out_pkb_q    <= PEAKBIN_W'(pkb_q);
					out_pitch_q  <= res_pitch_q;
				end
			end
			default: ;
		endcase
	end

	assign bin_ch.ready      = (state_q == ST_IDLE);
	assign res_ch.valid      = out_vld_q;
	assign res_ch.voiced     = out_voiced_q;
	assign res_ch.confidence = out_conf_q;
	assign res_ch.peak_bin   = out_pkb_q;
	assign res_ch.pitch      = out_pitch_q;

	// the tail starts only from an accepted end-of-row beat
	a_walk_from_eor: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_WALK) |-> $past(in_acc && bin_ch.end_of_row))
		else $error("window walk started without an end-of-row beat");

	// the walk never passes the clipped window end
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (walk_q <= last_q))
		else $error("window walk past its last bin");

	// weighted mean bin never lies past the last bin, so the offset stays within the span
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (div_quo <= QUO_W'(span)))
		else $error("pitch offset exceeds the pitch span");

	// nothing is in flight in the shared unit while streaming
	a_mac_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!mac_busy && !rd_vld_s1))
		else $error("shared unit busy while taking bins");

endmodule

`default_nettype wire

@@ sv/sppd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sppd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ sv/sppd_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sppd_mac
	import sppd_pkg::*;
#(
	parameter int AW    = 22,
	parameter int BW    = 15,
	parameter int ACCW  = 49,
	parameter int SHIFT = 17
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mac_ctl_t        ctl,
	input  wire logic [AW-1:0]   a,
	input  wire logic [BW-1:0]   b,
	output logic                 busy,
	output logic [ACCW-1:0]      acc
);

	localparam int PW = AW + BW;

	mac_ctl_t          ctl_s1;
	logic [PW-1:0]     prod_s1;
	logic [ACCW-1:0]   acc_q;
	logic [ACCW-1:0]   addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(a) * PW'(b);
	end

	// upper partial product lands SHIFT bits up
	assign addend = ctl_s1.hi ? (ACCW'(prod_s1) << SHIFT) : ACCW'(prod_s1);

	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			acc_q <= (ctl_s1.clr ? '0 : acc_q) + addend;
		end
	end

	assign busy = ctl_s1.vld;
	assign acc  = acc_q;

endmodule

`default_nettype wire

@@ sv/sppd_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sppd_div #(
	parameter int NW = 64,
	parameter int VW = 33,
	parameter int QW = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [NW-1:0]  num,
	input  wire logic [VW-1:0]  dvs,
	output logic                done,
	output logic [QW-1:0]       quo
);

	localparam int CNTW = $clog2(QW + 1);

	logic [NW-1:0]   rem_q;
	logic [NW-1:0]   sub_q;
	logic [QW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic            ge;

	assign ge = rem_q >= sub_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division: one quotient bit per cycle, divisor walks down
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			sub_q <= NW'(dvs) << (QW - 1);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - sub_q;
			end
			sub_q <= sub_q >> 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

@@ sim/tb_salience_peak_pitch_decoder.sv @@
`timescale 1ns / 1ps

module tb_salience_peak_pitch_decoder;
	import sppd_pkg::*;

	localparam int ROW_BINS_MAX = 512;
	localparam int RIDX_W       = $clog2(ROW_BINS_MAX);
	localparam int WIN_HALF     = 4;
	localparam int SETTLE       = 48;
	localparam int LONG_HOLD    = 200;
	localparam int RAND_BINS    = 360;
	localparam int LIMIT        = 300000;

	typedef struct packed {
		logic [SAL_W-1:0] salience;
		logic             end_of_row;
	} bin_beat_t;

	typedef struct packed {
		logic                 voiced;
		logic [SAL_W-1:0]     confidence;
		logic [PEAKBIN_W-1:0] peak_bin;
		logic [PITCH_W-1:0]   pitch;
	} row_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	sppd_in_if  bin_ch ();
	sppd_out_if res_ch ();

	salience_peak_pitch_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.bin_ch   (bin_ch),
		.res_ch   (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register shadows
	logic [BINS_W-1:0]  bins_reg = BINS_RST;
	logic [THR_W-1:0]   thr_reg  = THR_RST;
	logic [PITCH_W-1:0] lo_reg   = LO_RST;
	logic [PITCH_W-1:0] hi_reg   = HI_RST;

	// row state of the decoder as predicted
	logic [SAL_W-1:0] row_sal [ROW_BINS_MAX];
	int unsigned      row_cnt = 0;
	logic [SAL_W-1:0] pk_val  = '0;
	int unsigned      pk_idx  = 0;

	bin_beat_t   bin_q [$];
	row_result_t row_results_due [$];
	int unsigned bins_queued = 0;
	int unsigned bins_taken  = 0;
	int unsigned rand_bins   = 0;
	int unsigned mismatches  = 0;
	int unsigned cycles      = 0;

	logic        tx_idle = 1'b1;
	logic        rx_idle = 1'b1;
	int unsigned gap_left   = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left  = 0;
	logic        want_long_hold = 1'b0;
	logic        long_hold_done = 1'b0;

	function automatic int unsigned draw_idle();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic int unsigned row_limit();
		if (bins_reg == 0)
			return 1;
		if (bins_reg > ROW_BINS_MAX)
			return ROW_BINS_MAX;
		return 32'(bins_reg);
	endfunction

	function automatic logic [PITCH_W-1:0] window_pitch(int unsigned first, int unsigned last,
			output longint unsigned wsum);
		longint unsigned w, s, d, span, den, q;
		longint          base, res;
		logic            down;
		w = 0;
		s = 0;
		d = (row_limit() > 1) ? 64'(row_limit() - 1) : 64'd1;
		for (int unsigned i = first; i <= last; i++) begin
			w += 64'(row_sal[i[RIDX_W-1:0]]);
			s += 64'(row_sal[i[RIDX_W-1:0]]) * 64'(i);
		end
		wsum = w;
		if (w == 0)
			return '0;
		down = hi_reg < lo_reg;
		span = down ? 64'(lo_reg) - 64'(hi_reg) : 64'(hi_reg) - 64'(lo_reg);
		den  = w * d;
		// round half away from zero on the magnitude
		q    = (64'd2 * span * s + den) / (64'd2 * den);
		base = 64'(lo_reg);
		res  = down ? base - longint'(q) : base + longint'(q);
		if (res < 0)
			res = 0;
		if (res > 32767)
			res = 32767;
		return res[PITCH_W-1:0];
	endfunction

	function automatic void decode_bin(logic [SAL_W-1:0] sal, logic eor);
		int unsigned     first, last;
		longint unsigned wsum;
		row_result_t     r;
		// drop bins beyond the row length
		if (row_cnt < row_limit()) begin
			row_sal[row_cnt[RIDX_W-1:0]] = sal;
			if (row_cnt == 0 || sal > pk_val) begin
				pk_val = sal;
				pk_idx = row_cnt;
			end
			row_cnt++;
		end
		if (eor) begin
			r            = '0;
			r.confidence = pk_val;
			r.peak_bin   = pk_idx[PEAKBIN_W-1:0];
			if (pk_val > thr_reg && row_cnt > 0) begin
				first = (pk_idx > WIN_HALF) ? pk_idx - WIN_HALF : 0;
				last  = pk_idx + WIN_HALF;
				if (last > row_cnt - 1)
					last = row_cnt - 1;
				r.pitch  = window_pitch(first, last, wsum);
				r.voiced = (wsum != 0);
				if (wsum == 0)
					r.pitch = '0;
			end
			row_results_due.insert(row_results_due.size(), r);
			row_cnt = 0;
			pk_val  = '0;
			pk_idx  = 0;
		end
	endfunction

	function automatic void report_mismatch(string what, row_result_t want, row_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: want voiced=%0d conf=%0d bin=%0d pitch=%0d, %s",
				$time, what, want.voiced, want.confidence, want.peak_bin, want.pitch,
				$sformatf("got voiced=%0d conf=%0d bin=%0d pitch=%0d",
					got.voiced, got.confidence, got.peak_bin, got.pitch));
	endfunction

	// bin driver
	always @(posedge clk) begin : drive_bins
		bin_beat_t nb;
		if (arst_n) begin
			if (!bin_ch.valid || bin_ch.ready) begin
				if (gap_left != 0) begin
					bin_ch.valid <= 1'b0;
					gap_left     <= gap_left - 1;
				end else if (bin_q.size() != 0) begin
					nb = bin_q.pop_front();
					bin_ch.valid      <= 1'b1;
					bin_ch.salience   <= nb.salience;
					bin_ch.end_of_row <= nb.end_of_row;
					gap_left          <= tx_idle ? draw_idle() : 0;
				end else begin
					bin_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result ready, with a random stall after each beat while rx_idle is set
	always @(posedge clk) begin : drive_ready
		int unsigned s;
		if (arst_n) begin
			s = stall_left;
			if (res_ch.valid && res_ch.ready)
				s = rx_idle ? draw_idle() : 0;
			else if (s != 0)
				s = s - 1;
			stall_left   <= s;
			res_ch.ready <= (s == 0) && (hold_left == 0);
		end
	end

	// long hold-off on the result side to back the block up
	always @(posedge clk) begin
		if (want_long_hold && !long_hold_done) begin
			hold_left      <= LONG_HOLD;
			long_hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && bin_ch.valid && bin_ch.ready) begin
			decode_bin(bin_ch.salience, bin_ch.end_of_row);
			bins_taken++;
		end
	end

	always @(posedge clk) begin : check_results
		row_result_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.voiced     = res_ch.voiced;
			got.confidence = res_ch.confidence;
			got.peak_bin   = res_ch.peak_bin;
			got.pitch      = res_ch.pitch;
			if (row_results_due.size() == 0) begin
				report_mismatch("result with nothing pending", '0, got);
			end else begin
				want = row_results_due.pop_front();
				if (got.voiced !== want.voiced || got.confidence !== want.confidence ||
						got.peak_bin !== want.peak_bin || got.pitch !== want.pitch)
					report_mismatch("result mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		case (idx)
			REG_BINS: bins_reg = data[BINS_W-1:0];
			REG_THR:  thr_reg  = data[THR_W-1:0];
			REG_LO:   lo_reg   = data[PITCH_W-1:0];
			REG_HI:   hi_reg   = data[PITCH_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_bin(logic [SAL_W-1:0] sal, logic eor);
		bin_q.insert(bin_q.size(), '{sal, eor});
		bins_queued++;
	endtask

	task automatic drain();
		while (bins_taken != bins_queued || row_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// one row of random content: noise, peaked, sparse, tied or low-level noise
	task automatic queue_row(int unsigned len);
		int unsigned      shape, p, dist_p;
		logic [SAL_W-1:0] pv, v;
		shape = $urandom_range(0, 4);
		p     = $urandom_range(0, len - 1);
		pv    = SAL_W'($urandom);
		for (int unsigned i = 0; i < len; i++) begin
			dist_p = (i > p) ? i - p : p - i;
			case (shape)
				0: v = SAL_W'($urandom);
				1: begin
					if (i == p)
						v = pv;
					else if (dist_p <= WIN_HALF)
						v = SAL_W'($urandom_range(0, pv));
					else
						v = SAL_W'($urandom_range(0, pv / 2));
				end
				2: v = ($urandom_range(0, 7) == 0) ? SAL_W'($urandom_range(0, 255)) : '0;
				3: v = $urandom_range(0, 1) ? pv : '0;
				default: v = SAL_W'($urandom_range(0, 255));
			endcase
			push_bin(v, i == len - 1);
			rand_bins++;
		end
	endtask

	task automatic random_config();
		int unsigned pick;
		logic [PITCH_W-1:0] lo, hi;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			write_reg(REG_BINS, CFG_DATA_W'($urandom_range(2, 12)));
		else if (pick < 9)
			write_reg(REG_BINS, CFG_DATA_W'($urandom_range(13, 40)));
		else
			write_reg(REG_BINS, CFG_DATA_W'($urandom_range(41, 120)));
		pick = $urandom_range(0, 7);
		if (pick < 4)
			write_reg(REG_THR, CFG_DATA_W'($urandom_range(0, 4000)));
		else if (pick < 6)
			write_reg(REG_THR, CFG_DATA_W'($urandom_range(0, 65535)));
		else if (pick == 6)
			write_reg(REG_THR, 16'd0);
		else
			write_reg(REG_THR, 16'hFFFF);
		lo   = PITCH_W'($urandom_range(0, 32767));
		hi   = PITCH_W'($urandom_range(0, 32767));
		pick = $urandom_range(0, 7);
		if (pick == 0)
			hi = lo;
		else if (pick == 1) begin
			lo = PITCH_MAX;
			hi = '0;
		end
		write_reg(REG_LO, CFG_DATA_W'(lo));
		write_reg(REG_HI, CFG_DATA_W'(hi));
	endtask

	initial begin : run_test
		int unsigned start, lim, len, pick;
		logic        first_phase;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_idx               = REG_BINS;
		cfg_data              = '0;
		bin_ch.valid          = 1'b0;
		bin_ch.salience       = '0;
		bin_ch.end_of_row     = 1'b0;
		res_ch.ready          = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: lone zero bin, peak equal to threshold, tied peak, single full bin
		push_bin(16'd0, 1'b1);
		push_bin(THR_RST, 1'b0);
		push_bin(16'd100, 1'b1);
		push_bin(16'd100, 1'b0);
		push_bin(16'd3278, 1'b0);
		push_bin(16'd3278, 1'b0);
		push_bin(16'd50, 1'b1);
		push_bin(16'hFFFF, 1'b1);
		drain();

		// two-bin rows over the full pitch range, zero threshold
		write_reg(REG_BINS, 16'd2);
		write_reg(REG_THR, 16'd0);
		write_reg(REG_LO, 16'd0);
		write_reg(REG_HI, CFG_DATA_W'(PITCH_MAX));
		push_bin(16'd0, 1'b0);
		push_bin(16'hFFFF, 1'b1);
		push_bin(16'hFFFF, 1'b0);
		push_bin(16'd0, 1'b0);
		push_bin(16'd9, 1'b1);
		push_bin(16'd0, 1'b0);
		push_bin(16'd0, 1'b1);
		push_bin(16'd1, 1'b0);
		push_bin(16'd1, 1'b1);
		drain();

		// downward map, short row, then the top threshold
		tx_idle = 1'b0;
		write_reg(REG_BINS, 16'd16);
		write_reg(REG_THR, 16'd65534);
		write_reg(REG_LO, CFG_DATA_W'(PITCH_MAX));
		write_reg(REG_HI, 16'd0);
		for (int unsigned i = 0; i < 6; i++)
			push_bin((i == 3) ? 16'hFFFF : 16'($urandom_range(0, 65534)), i == 5);
		push_bin(16'd10, 1'b0);
		push_bin(16'd20, 1'b0);
		push_bin(16'hFFFF, 1'b1);
		drain();
		write_reg(REG_THR, 16'hFFFF);
		push_bin(16'hFFFF, 1'b0);
		push_bin(16'hFFFF, 1'b1);
		drain();

		// zero row length acts as a single bin; later bins of the row are dropped
		write_reg(REG_BINS, 16'd0);
		write_reg(REG_THR, 16'd0);
		write_reg(REG_LO, 16'd1000);
		write_reg(REG_HI, CFG_DATA_W'(PITCH_MAX));
		push_bin(16'd7, 1'b0);
		push_bin(16'hFFFF, 1'b1);
		push_bin(16'd0, 1'b1);
		drain();

		first_phase = 1'b1;
		while (rand_bins < RAND_BINS) begin
			tx_idle = first_phase ? 1'b0 : ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			random_config();
			lim   = row_limit();
			start = rand_bins;
			while (rand_bins - start < 40) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					len = lim;
				else if (pick < 8)
					len = $urandom_range(1, lim);
				else
					len = lim + $urandom_range(1, 4);
				queue_row(len);
			end
			if (first_phase)
				want_long_hold = 1'b1;
			first_phase = 1'b0;
			drain();
		end

		if (mismatches == 0 && row_results_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/sppd_pkg.sv
sv/sppd_in_if.sv
sv/sppd_out_if.sv
sv/sppd_ram.sv
sv/sppd_mac.sv
sv/sppd_div.sv
sv/salience_peak_pitch_decoder.sv
sim/tb_salience_peak_pitch_decoder.sv
